@@ rtl/vcce_pkg.sv @@
// vcce_pkg: shared types, codes and constants for the vsock credit engine
// used by vcce_step and vsock_connection_credit_engine; no dependencies
package vcce_pkg;

    localparam int unsigned CntW      = 32;
    localparam int unsigned LenW      = 17;
    localparam int unsigned TickW     = 5;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 32;

    localparam logic [CntW-1:0]  OwnAllocReset  = 32'd131072;
    localparam logic [LenW-1:0]  MaxChunkReset  = 17'd65536;
    localparam logic [TickW-1:0] TimeoutReset   = 5'd30;
    localparam logic [LenW-1:0]  ChunkLimit     = 17'd65536;

    typedef enum logic [2:0] {
        OP_RX         = 3'd0,
        OP_CONNECT    = 3'd1,
        OP_DATA_READY = 3'd2,
        OP_HANGUP     = 3'd3,
        OP_TICK       = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        RX_RESPONSE   = 3'd2,
        RX_RST        = 3'd3,
        RX_SHUTDOWN   = 3'd4,
        RX_DATA       = 3'd5,
        RX_CREDIT_UPD = 3'd6,
        RX_CREDIT_REQ = 3'd7
    } rx_kind_t;

    typedef enum logic [2:0] {
        SEND_NONE       = 3'd0,
        SEND_REQUEST    = 3'd1,
        SEND_DATA       = 3'd2,
        SEND_SHUTDOWN   = 3'd3,
        SEND_CREDIT_UPD = 3'd4,
        SEND_CREDIT_REQ = 3'd5
    } send_kind_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_OWN_ALLOC = 2'd0,
        CFG_MAX_CHUNK = 2'd1,
        CFG_TIMEOUT   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]      op;
        logic [2:0]      rx_kind;
        logic [LenW-1:0] rx_payload_len;
        logic [CntW-1:0] rx_peer_alloc;
        logic [CntW-1:0] rx_peer_forwarded;
        logic [LenW-1:0] offered_len;
    } event_t;

    typedef struct packed {
        logic [CntW-1:0]  own_buffer_alloc;
        logic [LenW-1:0]  max_chunk;
        logic [TickW-1:0] connect_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic             link_up;
        logic             awaiting_response;
        logic             client_present;
        logic [TickW-1:0] wait_ticks;
        logic [CntW-1:0]  forwarded_count;
        logic [CntW-1:0]  sent_count;
        logic [CntW-1:0]  peer_alloc;
        logic [CntW-1:0]  peer_forwarded;
    } conn_state_t;

    typedef struct packed {
        logic [2:0]      send_kind;
        logic [LenW-1:0] send_len;
        logic [CntW-1:0] send_alloc;
        logic [CntW-1:0] send_forwarded;
        logic [LenW-1:0] deliver_len;
        logic            close_local;
        logic            is_connected;
        logic            timed_out;
    } result_t;

endpackage

@@ rtl/vcce_step.sv @@
// vcce_step: next connection state and result word for one event
// depends on vcce_pkg
module vcce_step
    import vcce_pkg::*;
(
    input  event_t      ev,
    input  cfg_t        cfg,
    input  conn_state_t cur,
    output conn_state_t nxt,
    output result_t     res
);

    logic [CntW-1:0]  fwd_sum;
    logic [CntW-1:0]  fwd_gap;
    logic [CntW-1:0]  credit;
    logic [LenW-1:0]  chunk;
    logic [LenW-1:0]  n_credit;
    logic [LenW-1:0]  n_send;
    logic [TickW-1:0] limit;
    logic [TickW-1:0] ticks_inc;
    logic [2:0]       skind;

    always_comb
    begin
        fwd_sum   = cur.forwarded_count + {{(CntW-LenW){1'b0}}, ev.rx_payload_len};
        fwd_gap   = fwd_sum - cur.peer_forwarded;
        credit    = cur.peer_alloc - (cur.sent_count - cur.peer_forwarded);
        if (cfg.max_chunk == '0)
            chunk = {{(LenW-1){1'b0}}, 1'b1};
        else if (cfg.max_chunk > ChunkLimit)
            chunk = ChunkLimit;
        else
            chunk = cfg.max_chunk;
        if (credit < {{(CntW-LenW){1'b0}}, ev.offered_len})
            n_credit = credit[LenW-1:0];
        else
            n_credit = ev.offered_len;
        n_send    = (chunk < n_credit) ? chunk : n_credit;
        limit     = (cfg.connect_timeout_ticks == '0) ? {{(TickW-1){1'b0}}, 1'b1}
                                                      : cfg.connect_timeout_ticks;
        ticks_inc = cur.wait_ticks + {{(TickW-1){1'b0}}, 1'b1};
    end

    always_comb
    begin
        nxt             = cur;
        skind           = SEND_NONE;
        res             = '0;
        case (ev.op)
            OP_RX:
            begin
                case (ev.rx_kind)
                    RX_RESPONSE:
                    begin
                        if (cur.awaiting_response)
                        begin
                            nxt.link_up           = 1'b1;
                            nxt.awaiting_response = 1'b0;
                            nxt.wait_ticks        = '0;
                            nxt.peer_alloc        = ev.rx_peer_alloc;
                            nxt.peer_forwarded    = ev.rx_peer_forwarded;
                        end
                    end
                    RX_RST, RX_SHUTDOWN:
                    begin
                        nxt.link_up           = 1'b0;
                        nxt.awaiting_response = 1'b0;
                        nxt.wait_ticks        = '0;
                        nxt.client_present    = 1'b0;
                        res.close_local       = cur.client_present;
                    end
                    RX_DATA:
                    begin
                        if (cur.client_present && ev.rx_payload_len != '0)
                        begin
                            res.deliver_len     = ev.rx_payload_len;
                            nxt.forwarded_count = fwd_sum;
                            if (fwd_gap > {2'b00, cfg.own_buffer_alloc[CntW-1:2]})
                                skind = SEND_CREDIT_UPD;
                        end
                        nxt.peer_alloc     = ev.rx_peer_alloc;
                        nxt.peer_forwarded = ev.rx_peer_forwarded;
                    end
                    RX_CREDIT_UPD:
                    begin
                        nxt.peer_alloc     = ev.rx_peer_alloc;
                        nxt.peer_forwarded = ev.rx_peer_forwarded;
                    end
                    RX_CREDIT_REQ:
                    begin
                        skind = SEND_CREDIT_UPD;
                    end
                    default:
                    begin
                        skind = SEND_NONE;
                    end
                endcase
            end
            OP_CONNECT:
            begin
                if (!cur.client_present)
                begin
                    nxt.client_present    = 1'b1;
                    nxt.awaiting_response = 1'b1;
                    nxt.link_up           = 1'b0;
                    nxt.wait_ticks        = '0;
                    nxt.forwarded_count   = '0;
                    nxt.sent_count        = '0;
                    skind                 = SEND_REQUEST;
                end
            end
            OP_DATA_READY:
            begin
                if (cur.link_up && cur.client_present && ev.offered_len != '0)
                begin
                    if (n_send == '0)
                        skind = SEND_CREDIT_REQ;
                    else
                    begin
                        skind          = SEND_DATA;
                        res.send_len   = n_send;
                        nxt.sent_count = cur.sent_count + {{(CntW-LenW){1'b0}}, n_send};
                    end
                end
            end
            OP_HANGUP:
            begin
                if (cur.client_present)
                begin
                    skind                 = SEND_SHUTDOWN;
                    nxt.client_present    = 1'b0;
                    res.close_local       = 1'b1;
                    nxt.link_up           = 1'b0;
                    nxt.awaiting_response = 1'b0;
                    nxt.wait_ticks        = '0;
                end
            end
            OP_TICK:
            begin
                if (cur.awaiting_response)
                begin
                    nxt.wait_ticks = ticks_inc;
                    if (ticks_inc >= limit)
                    begin
                        res.timed_out         = 1'b1;
                        res.close_local       = cur.client_present;
                        nxt.client_present    = 1'b0;
                        nxt.awaiting_response = 1'b0;
                        nxt.wait_ticks        = '0;
                    end
                end
            end
            default:
            begin
                skind = SEND_NONE;
            end
        endcase
        res.send_kind    = skind;
        res.send_alloc   = (skind != SEND_NONE) ? cfg.own_buffer_alloc : '0;
        res.send_forwarded = (skind != SEND_NONE) ? nxt.forwarded_count : '0;
        res.is_connected = nxt.link_up;
    end

endmodule

@@ rtl/vsock_connection_credit_engine.sv @@
// vsock_connection_credit_engine: top level, event input register, state and result register
// depends on vcce_pkg and vcce_step
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  event in | in_valid / in_ready   | op rx_kind rx_payload_len rx_peer_alloc
//           |                       | rx_peer_forwarded offered_len
//  result   | out_valid / out_ready | send_kind send_len send_alloc send_forwarded
//           |                       | deliver_len close_local is_connected timed_out
//  config   | cfg_we                | cfg_index cfg_data
//
// one event per cycle sustained while out_ready is high; an event passes through
// the input register, then step logic into the result register
// the step logic reads the connection state and updates it as the result is registered
// reset clears connection state and loads register defaults; no clearing pass
// a stalled result holds; the input register still takes one event behind it
module vsock_connection_credit_engine
    import vcce_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          op,
    input  logic [2:0]          rx_kind,
    input  logic [LenW-1:0]     rx_payload_len,
    input  logic [CntW-1:0]     rx_peer_alloc,
    input  logic [CntW-1:0]     rx_peer_forwarded,
    input  logic [LenW-1:0]     offered_len,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          send_kind,
    output logic [LenW-1:0]     send_len,
    output logic [CntW-1:0]     send_alloc,
    output logic [CntW-1:0]     send_forwarded,
    output logic [LenW-1:0]     deliver_len,
    output logic                close_local,
    output logic                is_connected,
    output logic                timed_out
);

    cfg_t        cfg_reg;
    event_t      ev_reg;
    logic        ev_valid_reg;
    conn_state_t state_reg;
    conn_state_t state_next;
    result_t     res_reg;
    result_t     res_next;
    logic        out_valid_reg;
    logic        advance;

    assign advance  = ev_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !ev_valid_reg || advance;

    vcce_step u_step
    (
        .ev  (ev_reg),
        .cfg (cfg_reg),
        .cur (state_reg),
        .nxt (state_next),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_buffer_alloc      <= OwnAllocReset;
            cfg_reg.max_chunk             <= MaxChunkReset;
            cfg_reg.connect_timeout_ticks <= TimeoutReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_ALLOC: cfg_reg.own_buffer_alloc      <= cfg_data[CntW-1:0];
                CFG_MAX_CHUNK: cfg_reg.max_chunk             <= cfg_data[LenW-1:0];
                CFG_TIMEOUT:   cfg_reg.connect_timeout_ticks <= cfg_data[TickW-1:0];
                default:       cfg_reg                       <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                ev_valid_reg <= in_valid;
            out_valid_reg <= advance || (out_valid_reg && !out_ready);
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ev_reg.op                <= op;
            ev_reg.rx_kind           <= rx_kind;
            ev_reg.rx_payload_len    <= rx_payload_len;
            ev_reg.rx_peer_alloc     <= rx_peer_alloc;
            ev_reg.rx_peer_forwarded <= rx_peer_forwarded;
            ev_reg.offered_len       <= offered_len;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid      = out_valid_reg;
    assign send_kind      = res_reg.send_kind;
    assign send_len       = res_reg.send_len;
    assign send_alloc     = res_reg.send_alloc;
    assign send_forwarded = res_reg.send_forwarded;
    assign deliver_len    = res_reg.deliver_len;
    assign close_local    = res_reg.close_local;
    assign is_connected   = res_reg.is_connected;
    assign timed_out      = res_reg.timed_out;

endmodule

@@ verif/tb_vsock_connection_credit_engine.sv @@
// tb_vsock_connection_credit_engine: self-checking bench for the vsock credit engine,
// with a scoreboard class that predicts each result word from its own connection state
// depends on vcce_pkg and vsock_connection_credit_engine
module tb_vsock_connection_credit_engine;
    import vcce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit   = 4000;
    localparam int LongHold     = 400;
    localparam int PhaseItems   = 180;
    localparam int NumPhases    = 8;
    localparam int SettleCycles = 4;

    class credit_scoreboard;
        cfg_t        regs;
        conn_state_t conn;
        result_t     pending_q[$];
        int          errors;

        function new();
            regs.own_buffer_alloc      = OwnAllocReset;
            regs.max_chunk             = MaxChunkReset;
            regs.connect_timeout_ticks = TimeoutReset;
            conn   = '0;
            errors = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CfgDataW-1:0] val);
            case (idx)
                CFG_OWN_ALLOC: regs.own_buffer_alloc = val;
                CFG_MAX_CHUNK: regs.max_chunk = val[LenW-1:0];
                CFG_TIMEOUT:   regs.connect_timeout_ticks = val[TickW-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        function void note_event(event_t ev);
            result_t          r;
            logic [CntW-1:0]  credit;
            logic [CntW-1:0]  unacked;
            logic [LenW-1:0]  chunk;
            logic [LenW-1:0]  n;
            logic [TickW-1:0] limit;
            r = '0;
            case (ev.op)
                OP_RX:
                begin
                    case (ev.rx_kind)
                        RX_RESPONSE:
                        begin
                            if (conn.awaiting_response)
                            begin
                                conn.link_up           = 1'b1;
                                conn.awaiting_response = 1'b0;
                                conn.wait_ticks        = '0;
                                conn.peer_alloc        = ev.rx_peer_alloc;
                                conn.peer_forwarded    = ev.rx_peer_forwarded;
                            end
                        end
                        RX_RST, RX_SHUTDOWN:
                        begin
                            conn.link_up           = 1'b0;
                            conn.awaiting_response = 1'b0;
                            conn.wait_ticks        = '0;
                            if (conn.client_present)
                            begin
                                conn.client_present = 1'b0;
                                r.close_local       = 1'b1;
                            end
                        end
                        RX_DATA:
                        begin
                            if (conn.client_present && ev.rx_payload_len != '0)
                            begin
                                r.deliver_len        = ev.rx_payload_len;
                                conn.forwarded_count = conn.forwarded_count
                                                       + CntW'(ev.rx_payload_len);
                                unacked = conn.forwarded_count - conn.peer_forwarded;
                                if (unacked > (regs.own_buffer_alloc >> 2))
                                    r.send_kind = SEND_CREDIT_UPD;
                            end
                            conn.peer_alloc     = ev.rx_peer_alloc;
                            conn.peer_forwarded = ev.rx_peer_forwarded;
                        end
                        RX_CREDIT_UPD:
                        begin
                            conn.peer_alloc     = ev.rx_peer_alloc;
                            conn.peer_forwarded = ev.rx_peer_forwarded;
                        end
                        RX_CREDIT_REQ: r.send_kind = SEND_CREDIT_UPD;
                        default: ;
                    endcase
                end
                OP_CONNECT:
                begin
                    if (!conn.client_present)
                    begin
                        conn.client_present    = 1'b1;
                        conn.awaiting_response = 1'b1;
                        conn.link_up           = 1'b0;
                        conn.wait_ticks        = '0;
                        conn.forwarded_count   = '0;
                        conn.sent_count        = '0;
                        r.send_kind            = SEND_REQUEST;
                    end
                end
                OP_DATA_READY:
                begin
                    if (conn.link_up && conn.client_present && ev.offered_len != '0)
                    begin
                        credit = conn.peer_alloc - (conn.sent_count - conn.peer_forwarded);
                        chunk  = regs.max_chunk;
                        if (chunk == '0)
                            chunk = LenW'(1);
                        if (chunk > ChunkLimit)
                            chunk = ChunkLimit;
                        n = ev.offered_len;
                        if (credit < CntW'(n))
                            n = credit[LenW-1:0];
                        if (chunk < n)
                            n = chunk;
                        if (n == '0)
                            r.send_kind = SEND_CREDIT_REQ;
                        else
                        begin
                            r.send_kind     = SEND_DATA;
                            r.send_len      = n;
                            conn.sent_count = conn.sent_count + CntW'(n);
                        end
                    end
                end
                OP_HANGUP:
                begin
                    if (conn.client_present)
                    begin
                        r.send_kind            = SEND_SHUTDOWN;
                        r.close_local          = 1'b1;
                        conn.client_present    = 1'b0;
                        conn.link_up           = 1'b0;
                        conn.awaiting_response = 1'b0;
                        conn.wait_ticks        = '0;
                    end
                end
                OP_TICK:
                begin
                    if (conn.awaiting_response)
                    begin
                        limit = (regs.connect_timeout_ticks == '0) ? TickW'(1)
                                                                   : regs.connect_timeout_ticks;
                        conn.wait_ticks = conn.wait_ticks + 1'b1;
                        if (conn.wait_ticks >= limit)
                        begin
                            r.timed_out            = 1'b1;
                            r.close_local          = conn.client_present;
                            conn.client_present    = 1'b0;
                            conn.awaiting_response = 1'b0;
                            conn.wait_ticks        = '0;
                        end
                    end
                end
                default: ;
            endcase
            if (r.send_kind != SEND_NONE)
            begin
                r.send_alloc     = regs.own_buffer_alloc;
                r.send_forwarded = conn.forwarded_count;
            end
            r.is_connected = conn.link_up;
            pending_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [CntW-1:0] want, logic [CntW-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_q.size() == 0)
            begin
                $error("result word with nothing pending: send_kind %0d", got.send_kind);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            compare_field("send_kind", CntW'(want.send_kind), CntW'(got.send_kind));
            compare_field("send_len", CntW'(want.send_len), CntW'(got.send_len));
            compare_field("send_alloc", want.send_alloc, got.send_alloc);
            compare_field("send_forwarded", want.send_forwarded, got.send_forwarded);
            compare_field("deliver_len", CntW'(want.deliver_len), CntW'(got.deliver_len));
            compare_field("close_local", CntW'(want.close_local), CntW'(got.close_local));
            compare_field("is_connected", CntW'(want.is_connected), CntW'(got.is_connected));
            compare_field("timed_out", CntW'(want.timed_out), CntW'(got.timed_out));
        endfunction
    endclass

    logic                clk;
    logic                rst_n             = 1'b0;
    logic                cfg_we            = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index         = '0;
    logic [CfgDataW-1:0] cfg_data          = '0;
    logic                in_valid          = 1'b0;
    logic                in_ready;
    logic [2:0]          op                = '0;
    logic [2:0]          rx_kind           = '0;
    logic [LenW-1:0]     rx_payload_len    = '0;
    logic [CntW-1:0]     rx_peer_alloc     = '0;
    logic [CntW-1:0]     rx_peer_forwarded = '0;
    logic [LenW-1:0]     offered_len       = '0;
    logic                out_valid;
    logic                out_ready         = 1'b0;
    logic [2:0]          send_kind;
    logic [LenW-1:0]     send_len;
    logic [CntW-1:0]     send_alloc;
    logic [CntW-1:0]     send_forwarded;
    logic [LenW-1:0]     deliver_len;
    logic                close_local;
    logic                is_connected;
    logic                timed_out;

    credit_scoreboard sb;
    int   events_sent   = 0;
    logic sender_steady = 1'b0;
    logic sink_steady   = 1'b0;
    logic sink_holding  = 1'b0;

    vsock_connection_credit_engine i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_event(event_t'{op, rx_kind, rx_payload_len, rx_peer_alloc,
                                       rx_peer_forwarded, offered_len});
            if (out_valid && out_ready)
                sb.check_result(result_t'{send_kind, send_len, send_alloc, send_forwarded,
                                          deliver_len, close_local, is_connected, timed_out});
        end
    end

    function automatic event_t any_event(op_t o);
        event_t ev;
        ev.op                = o;
        ev.rx_kind           = 3'($urandom);
        ev.rx_payload_len    = LenW'($urandom_range(0, ChunkLimit));
        ev.rx_peer_alloc     = $urandom;
        ev.rx_peer_forwarded = $urandom;
        ev.offered_len       = LenW'($urandom_range(1, ChunkLimit));
        return ev;
    endfunction

    function automatic event_t noise_event();
        event_t ev;
        ev                = any_event(OP_TICK);
        ev.op             = 3'($urandom);
        ev.rx_payload_len = LenW'($urandom);
        ev.offered_len    = LenW'($urandom);
        return ev;
    endfunction

    function automatic event_t rx_packet(rx_kind_t k, logic [LenW-1:0] len,
                                         logic [CntW-1:0] alloc, logic [CntW-1:0] fwd);
        event_t ev;
        ev                   = any_event(OP_RX);
        ev.rx_kind           = k;
        ev.rx_payload_len    = len;
        ev.rx_peer_alloc     = alloc;
        ev.rx_peer_forwarded = fwd;
        return ev;
    endfunction

    function automatic event_t ready_event(logic [LenW-1:0] len);
        event_t ev;
        ev             = any_event(OP_DATA_READY);
        ev.offered_len = len;
        return ev;
    endfunction

    function automatic logic [LenW-1:0] pick_len();
        case ($urandom_range(0, 4))
            0:       return LenW'(1);
            1:       return LenW'($urandom_range(1, 64));
            2:       return LenW'($urandom_range(1, 4096));
            3:       return LenW'($urandom_range(1, ChunkLimit));
            default: return ChunkLimit;
        endcase
    endfunction

    function automatic logic [CntW-1:0] pick_alloc();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return CntW'($urandom_range(1, 4096));
            2:       return CntW'($urandom_range(65536, 262144));
            3:       return $urandom;
            default: return '1;
        endcase
    endfunction

    // peer acknowledgement somewhat behind what was sent
    function automatic logic [CntW-1:0] acked();
        return sb.conn.sent_count - CntW'($urandom_range(0, 4096));
    endfunction

    task automatic push_event(event_t ev);
        int gap;
        if ($urandom_range(0, 49) == 0)
            sender_steady = !sender_steady;
        gap = (sender_steady || sink_holding) ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        op                <= ev.op;
        rx_kind           <= ev.rx_kind;
        rx_payload_len    <= ev.rx_payload_len;
        rx_peer_alloc     <= ev.rx_peer_alloc;
        rx_peer_forwarded <= ev.rx_peer_forwarded;
        offered_len       <= ev.offered_len;
        do
            @(posedge clk);
        while (!in_ready);
        events_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic program_regs(logic [CfgDataW-1:0] alloc, logic [CfgDataW-1:0] chunk,
                                logic [CfgDataW-1:0] ticks);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OWN_ALLOC;
        cfg_data  <= alloc;
        @(posedge clk);
        sb.set_reg(CFG_OWN_ALLOC, alloc);
        cfg_index <= CFG_MAX_CHUNK;
        cfg_data  <= chunk;
        @(posedge clk);
        sb.set_reg(CFG_MAX_CHUNK, chunk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= ticks;
        @(posedge clk);
        sb.set_reg(CFG_TIMEOUT, ticks);
        cfg_we <= 1'b0;
    endtask

    task automatic run_session();
        logic [CntW-1:0] alloc;
        int              pick;
        push_event(any_event(OP_CONNECT));
        // let the connect wait run out
        if ($urandom_range(0, 9) == 0)
        begin
            repeat (32) push_event(any_event(OP_TICK));
            return;
        end
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) push_event(any_event(OP_TICK));
        alloc = pick_alloc();
        push_event(rx_packet(RX_RESPONSE, pick_len(), alloc,
                             ($urandom_range(0, 1) == 0) ? CntW'(0) : CntW'($urandom)));
        repeat ($urandom_range(4, 24))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                push_event(ready_event(pick_len()));
            else if (pick < 60)
                push_event(rx_packet(RX_DATA,
                                     ($urandom_range(0, 15) == 0) ? LenW'(0) : pick_len(),
                                     alloc, acked()));
            else if (pick < 72)
            begin
                alloc = pick_alloc();
                push_event(rx_packet(RX_CREDIT_UPD, pick_len(), alloc, acked()));
            end
            else if (pick < 80)
                push_event(rx_packet(RX_CREDIT_REQ, pick_len(), $urandom, $urandom));
            else if (pick < 88)
                push_event(any_event(OP_TICK));
            else if (pick < 92)
                push_event(rx_packet(RX_RESPONSE, pick_len(), $urandom, $urandom));
            else if (pick < 96)
                push_event(any_event(OP_CONNECT));
            else
                push_event(noise_event());
        end
        pick = $urandom_range(0, 9);
        if (pick < 5)
            push_event(any_event(OP_HANGUP));
        else if (pick < 7)
            push_event(rx_packet(RX_RST, pick_len(), $urandom, $urandom));
        else if (pick < 8)
            push_event(rx_packet(RX_SHUTDOWN, pick_len(), $urandom, $urandom));
    endtask

    initial
    begin : result_sink
        int stall;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                sink_steady = !sink_steady;
            // long hold so the engine backs up into its input
            if (taken == 300 || taken == 1000)
                stall = LongHold;
            else if (sink_steady)
                stall = 0;
            else
                stall = $urandom_range(0, 19);
            if (stall > 0)
            begin
                sink_holding = (stall == LongHold);
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                sink_holding = 1'b0;
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < StallLimit)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_vsock_connection_credit_engine: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        event_t ev;
        int     phase_start;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values, no client yet
        ev    = noise_event();
        ev.op = 3'($urandom_range(int'(OP_TICK) + 1, 7));
        push_event(ev);
        ev                   = any_event(OP_TICK);
        ev.op                = '1;
        ev.rx_kind           = '1;
        ev.rx_payload_len    = '1;
        ev.rx_peer_alloc     = '1;
        ev.rx_peer_forwarded = '1;
        ev.offered_len       = '1;
        push_event(ev);
        push_event(ready_event(ChunkLimit));
        push_event(any_event(OP_HANGUP));
        push_event(any_event(OP_TICK));
        push_event(rx_packet(RX_RESPONSE, '0, '1, '1));
        push_event(rx_packet(RX_DATA, ChunkLimit, '0, '0));
        push_event(any_event(OP_CONNECT));
        push_event(any_event(OP_CONNECT));
        push_event(any_event(OP_TICK));
        // zero credit, then a credit update opens the window
        push_event(rx_packet(RX_RESPONSE, '0, '0, '0));
        push_event(ready_event(LenW'(1)));
        push_event(rx_packet(RX_CREDIT_UPD, '0, '1, '0));
        push_event(ready_event('0));
        push_event(ready_event(ChunkLimit));
        push_event(ready_event(LenW'(1)));
        push_event(rx_packet(RX_DATA, ChunkLimit, '1, CntW'(65537)));
        push_event(rx_packet(RX_DATA, '0, '1, CntW'(65537)));
        repeat (2)
        begin
            ev         = rx_packet(RX_CREDIT_UPD, '1, '1, '1);
            ev.rx_kind = 3'($urandom_range(0, int'(RX_RESPONSE) - 1));
            push_event(ev);
        end
        push_event(rx_packet(RX_CREDIT_REQ, '0, '0, '0));
        push_event(rx_packet(RX_RST, '0, '0, '0));
        push_event(any_event(OP_CONNECT));
        push_event(any_event(OP_HANGUP));
        push_event(any_event(OP_CONNECT));
        push_event(rx_packet(RX_SHUTDOWN, '0, '0, '0));

        for (int p = 0; p < NumPhases; p++)
        begin
            settle();
            case (p)
                0: program_regs('0, '0, '0);
                1: program_regs('1, '1, '1);
                2: program_regs(CntW'(4096), CfgDataW'(1), CfgDataW'(1));
                3: program_regs(CntW'(65536), CfgDataW'(ChunkLimit), CfgDataW'(2));
                4: program_regs($urandom, CfgDataW'($urandom_range(1, ChunkLimit)),
                                CfgDataW'($urandom_range(1, 31)));
                5: program_regs(CntW'($urandom_range(0, 65536)),
                                CfgDataW'($urandom_range(1, 512)),
                                CfgDataW'($urandom_range(1, 4)));
                6: program_regs(OwnAllocReset, CfgDataW'(ChunkLimit) + 1, TimeoutReset);
                default: program_regs($urandom, $urandom, $urandom);
            endcase
            phase_start = events_sent;
            while (events_sent - phase_start < PhaseItems)
            begin
                if ($urandom_range(0, 99) < 85)
                    run_session();
                else
                    push_event(noise_event());
            end
        end

        settle();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_vsock_connection_credit_engine: done, clean");
        else
            $display("tb_vsock_connection_credit_engine: done, errors");
        $finish;
    end

endmodule
